// File: rtl/lom_pkg.sv
// ============================================================================
// lom_pkg: shared types for the limit order matcher
// Holds the order word carried from the front end to the match engine.
// ============================================================================
package lom_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] order_id;
    logic        order_side;
    logic        order_kind;
    logic [31:0] order_price;
    logic [31:0] order_quantity;
    logic [47:0] now_time;
  } order_t;

  localparam logic [1:0] STATUS_NEW     = 2'd0;
  localparam logic [1:0] STATUS_PARTIAL = 2'd1;
  localparam logic [1:0] STATUS_FILLED  = 2'd2;

endpackage

// File: rtl/lom_order_fifo.sv
// ============================================================================
// lom_order_fifo: two-entry order queue
// Decouples order intake from the match engine so each side stalls alone.
// ============================================================================
module lom_order_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lom_pkg::order_t in_word_i,
  output logic            out_valid_o,
  input  logic            out_pop_i,
  output lom_pkg::order_t out_word_o
);
  import lom_pkg::*;

  order_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_stall_o  = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_pop_i && out_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/lom_match_engine.sv
// ============================================================================
// lom_match_engine: book storage and match sequencer
// Scans the book one slot a cycle to find the best entry, emits one trade per
// match, then writes back and rests the leftover.
// ============================================================================
module lom_match_engine #(
  parameter int unsigned BOOK_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ord_valid_i,
  output logic            ord_pop_o,
  input  lom_pkg::order_t ord_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            record_kind_o,
  output logic [31:0]     buyer_id_o,
  output logic [31:0]     seller_id_o,
  output logic [31:0]     trade_price_o,
  output logic [31:0]     trade_qty_o,
  output logic [47:0]     trade_time_o,
  output logic [1:0]      order_status_o,
  output logic            rested_o,
  output logic            book_full_o,
  output logic            last_o
);
  import lom_pkg::*;

  localparam int unsigned IdxW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(BOOK_DEPTH + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(BOOK_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_SUM   = 5'b10000
  } state_e;

  // Book storage; valid bits and remaining quantities in flip-flops so that
  // a simulate run can keep a shadow copy without touching the book.
  logic [BOOK_DEPTH-1:0] valid_q, live_q;
  logic        side_q  [BOOK_DEPTH];
  logic [31:0] price_q [BOOK_DEPTH];
  logic [31:0] owner_q [BOOK_DEPTH];
  logic [31:0] arr_q   [BOOK_DEPTH];
  logic [31:0] rem_q   [BOOK_DEPTH];
  logic [31:0] shrem_q [BOOK_DEPTH];
  logic [31:0] arrival_q;

  state_e          state_q;
  order_t          ord_q;
  logic [31:0]     left_q;
  logic [CntW-1:0] scan_q;
  logic            found_q;
  logic [IdxW-1:0] best_q;
  logic [31:0]     bprice_q, bage_q;
  logic [31:0]     fill_q;
  logic            ovalid_q, ovalid_d;

  logic [IdxW-1:0] si;
  logic [31:0]     srem, brem, age, fill;
  logic            is_buy, cand, better, ok, commit, ws;

  assign si     = scan_q[IdxW-1:0];
  assign is_buy = !ord_q.order_side;
  assign commit = !ord_q.req_type;
  assign srem   = commit ? rem_q[best_q] : shrem_q[best_q];
  assign brem   = srem;
  assign age    = arrival_q - arr_q[si];
  assign cand   = live_q[si] && (side_q[si] != ord_q.order_side);
  assign better = !found_q ||
                  (is_buy ? (price_q[si] < bprice_q) : (price_q[si] > bprice_q)) ||
                  ((price_q[si] == bprice_q) && (age > bage_q));
  assign ok     = found_q && (ord_q.order_kind ||
                  (is_buy ? (bprice_q <= ord_q.order_price)
                          : (bprice_q >= ord_q.order_price)));
  assign fill   = (left_q < brem) ? left_q : brem;
  assign ws     = !ovalid_q || !out_stall_i;

  // A new word loads whenever the register is free; otherwise a stalled word holds.
  assign ovalid_d = (((state_q == ST_EMIT) || (state_q == ST_SUM)) && ws) ||
                    (ovalid_q && out_stall_i);

  assign ord_pop_o   = (state_q == ST_IDLE) && ord_valid_i;
  assign out_valid_o = ovalid_q;

  // First free slot after the write-back, for resting the leftover.
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  logic                  rest_ok;
  logic [BOOK_DEPTH-1:0] rest_mask;
  assign rest_ok = commit && (left_q != '0) && !ord_q.order_kind && free_found;
  always_comb begin
    rest_mask           = '0;
    rest_mask[free_idx] = rest_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      live_q    <= '0;
      arrival_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      case (state_q)
        ST_IDLE: begin
          if (ord_valid_i) begin
            state_q <= ST_SCAN;
            live_q  <= valid_q;
          end
        end
        ST_SCAN: begin
          if (scan_q == LastIdx) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (left_q != '0 && ok) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_SUM;
          end
        end
        ST_EMIT: begin
          if (ws) begin
            if (srem == fill_q) live_q[best_q] <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SUM: begin
          if (ws) begin
            state_q <= ST_IDLE;
            if (commit) valid_q <= live_q | rest_mask;
            if (rest_ok) arrival_q <= arrival_q + 32'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ord_q   <= ord_i;
        left_q  <= ord_i.order_quantity;
        scan_q  <= '0;
        found_q <= 1'b0;
        for (int i = 0; i < BOOK_DEPTH; i++) shrem_q[i] <= rem_q[i];
      end
      ST_SCAN: begin
        if (cand && better) begin
          found_q  <= 1'b1;
          best_q   <= si;
          bprice_q <= price_q[si];
          bage_q   <= age;
        end
        scan_q <= scan_q + CntW'(1);
      end
      ST_DECIDE: begin
        fill_q <= fill;
      end
      ST_EMIT: begin
        if (ws) begin
          record_kind_o  <= 1'b0;
          buyer_id_o     <= is_buy ? ord_q.order_id : owner_q[best_q];
          seller_id_o    <= is_buy ? owner_q[best_q] : ord_q.order_id;
          trade_price_o  <= bprice_q;
          trade_qty_o    <= fill_q;
          trade_time_o   <= ord_q.now_time;
          order_status_o <= STATUS_NEW;
          rested_o       <= 1'b0;
          book_full_o    <= 1'b0;
          last_o         <= 1'b0;
          left_q         <= left_q - fill_q;
          if (commit) rem_q[best_q] <= srem - fill_q;
          else        shrem_q[best_q] <= srem - fill_q;
          scan_q  <= '0;
          found_q <= 1'b0;
        end
      end
      ST_SUM: begin
        if (ws) begin
          record_kind_o  <= 1'b1;
          buyer_id_o     <= '0;
          seller_id_o    <= '0;
          trade_price_o  <= '0;
          trade_qty_o    <= '0;
          trade_time_o   <= '0;
          order_status_o <= (left_q == '0) ? STATUS_FILLED :
                            ((left_q < ord_q.order_quantity) ? STATUS_PARTIAL : STATUS_NEW);
          rested_o    <= commit && (left_q != '0) && !ord_q.order_kind && free_found;
          book_full_o <= commit && (left_q != '0) && !ord_q.order_kind && !free_found;
          last_o      <= 1'b1;
          if (commit && (left_q != '0) && !ord_q.order_kind && free_found) begin
            side_q[free_idx]  <= ord_q.order_side;
            price_q[free_idx] <= ord_q.order_price;
            owner_q[free_idx] <= ord_q.order_id;
            rem_q[free_idx]   <= left_q;
            arr_q[free_idx]   <= arrival_q;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/limit_order_matcher_core.sv
// ============================================================================
// limit_order_matcher_core: price-time priority order matcher
// Matches each order against a bounded resting book and reports trades and
// a closing summary word.
// ============================================================================
//  channel | direction | handshake           | word
//  order   | in        | in_valid_i/in_stall_o | request fields
//  record  | out       | out_valid_o/out_stall_i | trade or summary fields
//
// Each match costs a full scan of the book, one slot a cycle, plus a decide
// step and an emit step; an order with m matches scans the book m+1 times,
// then closes with a summary step. Reset empties the book at once through
// its valid bits. A two-word order queue keeps intake open while the engine
// is busy until the queue fills; an output stall holds the engine at its
// emit or summary step.
module limit_order_matcher_core #(
  parameter int unsigned BOOK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] order_id_i,
  input  logic        order_side_i,
  input  logic        order_kind_i,
  input  logic [31:0] order_price_i,
  input  logic [31:0] order_quantity_i,
  input  logic [47:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [31:0] buyer_id_o,
  output logic [31:0] seller_id_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] trade_qty_o,
  output logic [47:0] trade_time_o,
  output logic [1:0]  order_status_o,
  output logic        rested_o,
  output logic        book_full_o,
  output logic        last_o
);
  import lom_pkg::*;

  order_t in_word, q_word;
  logic   q_valid, q_pop;

  assign in_word = '{req_type: req_type_i, order_id: order_id_i,
                     order_side: order_side_i, order_kind: order_kind_i,
                     order_price: order_price_i,
                     order_quantity: order_quantity_i, now_time: now_time_i};

  // Front end: the order queue.
  lom_order_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_word_i(in_word),
    .out_valid_o(q_valid), .out_pop_i(q_pop), .out_word_o(q_word)
  );

  // Back end: book and matching sequencer.
  lom_match_engine #(.BOOK_DEPTH(BOOK_DEPTH)) u_engine (
    .clk_i, .rst_ni,
    .ord_valid_i(q_valid), .ord_pop_o(q_pop), .ord_i(q_word),
    .out_valid_o, .out_stall_i,
    .record_kind_o, .buyer_id_o, .seller_id_o, .trade_price_o, .trade_qty_o,
    .trade_time_o, .order_status_o, .rested_o, .book_full_o, .last_o
  );
endmodule

// File: rtl/lom_checker.sv
// ============================================================================
// lom_checker: port-level checks for the matcher
// Watches record words at the top level's ports.
// ============================================================================
module lom_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        record_kind_o,
  input logic        last_o,
  input logic [1:0]  order_status_o,
  input logic        rested_o,
  input logic        book_full_o
);
  import lom_pkg::*;

  // A summary word is always the last one, a trade never is.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == record_kind_o)) else $error("last mismatch");
  // Rested and book full never both set.
  a_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rested_o && book_full_o)) else $error("rest and full");
  // A summary never reports an unknown status.
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o) |-> (order_status_o <= STATUS_FILLED))
    else $error("bad status");
  // A stalled word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(record_kind_o)))
    else $error("word dropped");
endmodule

bind limit_order_matcher_core lom_checker u_lom_checker (.*);
